/* rtl/core/mvzr_pkg.sv */
// shared types and constants for the motion vector zero-run encoder
// no dependencies; imported by every module of the block

package mvzr_pkg;

    // field widths
    localparam int MV_W      = 8;
    localparam int VEC_W     = MV_W + 1;
    localparam int RUN_W     = 12;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 48;

    // register map
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIFF_MODE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ENTRIES = 1'b1;

    // defaults and limits
    localparam int unsigned MAX_VECTORS_DEF = 4096;
    localparam logic [CNT_W-1:0] ENTRY_CAP_LIMIT = 13'd4096;
    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 13'd4096;

    // one input request
    typedef struct packed {
        logic signed [MV_W-1:0] mv_x;
        logic signed [MV_W-1:0] mv_y;
        logic                   last_in_frame;
    } mv_item_t;

    // one result request
    typedef struct packed {
        logic        [IDX_W-1:0] entry_index;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_x;
        logic        [RUN_W-1:0] zero_run;
    } run_entry_t;

    // configuration write
    typedef struct packed {
        logic                  wr_en;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wr_data;
    } cfg_wr_t;

endpackage

/* rtl/core/mvzr_in_reg.sv */
// input register stage of the zero-run encoder
// depends on mvzr_pkg for the item type

module mvzr_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mvzr_pkg::mv_item_t s_item,
    input  logic              out_free,
    output logic              fire,
    output mvzr_pkg::mv_item_t item
);
    import mvzr_pkg::*;

    logic     valid_reg, valid_next;
    mv_item_t item_reg;

    // item leaves the stage whenever the result side can take it
    assign fire    = valid_reg && out_free;
    assign s_ready = !valid_reg || fire;
    assign item    = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

/* rtl/core/mvzr_coder.sv */
// run/prediction state, config registers and entry formation
// depends on mvzr_pkg for types, widths and register codes

module mvzr_coder #(
    parameter int unsigned MAX_VECTORS = mvzr_pkg::MAX_VECTORS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mvzr_pkg::cfg_wr_t    cfg,
    input  logic                 fire,
    input  mvzr_pkg::mv_item_t   item,
    output logic                 res_load,
    output mvzr_pkg::run_entry_t res
);
    import mvzr_pkg::*;

    localparam int unsigned RunCapInt = (MAX_VECTORS - 1 < 4095) ? MAX_VECTORS - 1 : 4095;
    localparam logic [RUN_W-1:0] RunCap = RUN_W'(RunCapInt);

    logic                    diff_mode_reg;
    logic [CNT_W-1:0]        max_entries_reg;
    logic [RUN_W-1:0]        run_count_reg, run_count_next;
    logic signed [MV_W-1:0]  pred_x_reg, pred_x_next;
    logic signed [MV_W-1:0]  pred_y_reg, pred_y_next;
    logic [CNT_W-1:0]        entries_sent_reg, entries_sent_next;

    logic [CNT_W-1:0]        eff_cap;
    logic                    active;
    logic signed [VEC_W-1:0] cx, cy;
    logic                    nonzero;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_mode_reg   <= 1'b0;
            max_entries_reg <= MAX_ENTRIES_RST;
        end else if (cfg.wr_en) begin
            case (cfg.addr)
                CFG_DIFF_MODE:   diff_mode_reg   <= cfg.wr_data[0];
                CFG_MAX_ENTRIES: max_entries_reg <= cfg.wr_data;
                default: ;
            endcase
        end
    end

    // coded value and cap check
    assign eff_cap = (max_entries_reg > ENTRY_CAP_LIMIT) ? ENTRY_CAP_LIMIT : max_entries_reg;
    assign active  = entries_sent_reg < eff_cap;
    assign cx = diff_mode_reg ? ({item.mv_x[MV_W-1], item.mv_x} - {pred_x_reg[MV_W-1], pred_x_reg})
                              : {item.mv_x[MV_W-1], item.mv_x};
    assign cy = diff_mode_reg ? ({item.mv_y[MV_W-1], item.mv_y} - {pred_y_reg[MV_W-1], pred_y_reg})
                              : {item.mv_y[MV_W-1], item.mv_y};
    assign nonzero = (cx != '0) || (cy != '0);

    assign res_load        = fire && active && nonzero;
    assign res.zero_run    = run_count_reg;
    assign res.vec_x       = cx;
    assign res.vec_y       = cy;
    assign res.entry_index = entries_sent_reg[IDX_W-1:0];

    // state update per request
    always_comb begin
        run_count_next    = run_count_reg;
        pred_x_next       = pred_x_reg;
        pred_y_next       = pred_y_reg;
        entries_sent_next = entries_sent_reg;
        if (fire) begin
            if (active) begin
                if (nonzero) begin
                    entries_sent_next = entries_sent_reg + 1'b1;
                    run_count_next    = '0;
                end else if (run_count_reg < RunCap) begin
                    run_count_next = run_count_reg + 1'b1;
                end
                pred_x_next = item.mv_x;
                pred_y_next = item.mv_y;
            end
            // frame end drops any pending run
            if (item.last_in_frame) begin
                run_count_next    = '0;
                pred_x_next       = '0;
                pred_y_next       = '0;
                entries_sent_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_count_reg    <= '0;
            pred_x_reg       <= '0;
            pred_y_reg       <= '0;
            entries_sent_reg <= '0;
        end else begin
            run_count_reg    <= run_count_next;
            pred_x_reg       <= pred_x_next;
            pred_y_reg       <= pred_y_next;
            entries_sent_reg <= entries_sent_next;
        end
    end

`ifndef SYNTH
    a_entries_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entries_sent_reg <= ENTRY_CAP_LIMIT)
        else $error("entry count beyond limit");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_count_reg <= RunCap)
        else $error("zero run beyond saturation value");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last_in_frame |=> run_count_reg == '0 && entries_sent_reg == '0
            && pred_x_reg == '0 && pred_y_reg == '0)
        else $error("state not cleared after frame end");

    // an entry inside a frame restarts the run and counts
    a_run_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && !item.last_in_frame |=> run_count_reg == '0 && entries_sent_reg != '0)
        else $error("entry emitted without run restart");
`endif

endmodule

/* rtl/core/mvzr_out_reg.sv */
// result register stage of the zero-run encoder
// depends on mvzr_pkg for the entry type

module mvzr_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_load,
    input  mvzr_pkg::run_entry_t res,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mvzr_pkg::run_entry_t m_entry,
    output logic                 out_free
);
    import mvzr_pkg::*;

    logic       valid_reg, valid_next;
    run_entry_t entry_reg;

    assign m_valid  = valid_reg;
    assign m_entry  = entry_reg;
    assign out_free = !valid_reg || m_ready;

    // hold until taken, reload on a new entry
    always_comb begin
        valid_next = valid_reg;
        if (res_load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            entry_reg <= res;
        end
    end

endmodule

/* rtl/core/motion_vector_zero_run_encoder.sv */
// top level of the motion vector zero-run encoder
// depends on mvzr_pkg, mvzr_in_reg, mvzr_coder and mvzr_out_reg
//
// channel  | direction | data                                   | sideband
// ---------+-----------+----------------------------------------+----------------
// s_       | in        | mv_x, mv_y                             | tlast = last_in_frame
// m_       | out       | zero_run, vec_x, vec_y, entry_index    | none
// cfg_     | in        | diff_mode (0), max_entries (1)         | write only
//
// one vector per cycle unless m_tready stalls; a request passes the input and result registers
// the run, prediction and entry count registers feed back through combinational logic only
// zero vectors and capped vectors produce no result request
// reset (aresetn low, synchronous) clears run, prediction and entry count, and sets config to defaults
// a stall on m_tready holds the result register and back-pressures s_tready

module motion_vector_zero_run_encoder #(
    parameter int unsigned MAX_VECTORS = mvzr_pkg::MAX_VECTORS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // mv_x [7:0], mv_y [15:8]
    input  logic [mvzr_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                s_tlast,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // zero_run [11:0], vec_x [20:12], vec_y [29:21], entry_index [41:30], zero fill
    output logic [mvzr_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [mvzr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mvzr_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import mvzr_pkg::*;

    mv_item_t   s_item, item;
    run_entry_t res, m_entry;
    cfg_wr_t    cfg;
    logic       fire, out_free, res_load;

    // unpack input request
    assign s_item.mv_x          = s_tdata[MV_W-1:0];
    assign s_item.mv_y          = s_tdata[2*MV_W-1:MV_W];
    assign s_item.last_in_frame = s_tlast;

    assign cfg.wr_en   = cfg_wr_en;
    assign cfg.addr    = cfg_addr;
    assign cfg.wr_data = cfg_wr_data;

    mvzr_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_item   (s_item),
        .out_free (out_free),
        .fire     (fire),
        .item     (item)
    );

    mvzr_coder #(
        .MAX_VECTORS (MAX_VECTORS)
    ) u_coder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .fire     (fire),
        .item     (item),
        .res_load (res_load),
        .res      (res)
    );

    mvzr_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_load (res_load),
        .res      (res),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_entry  (m_entry),
        .out_free (out_free)
    );

    // pack result request, lowest field first
    assign m_tdata = {{(M_DATA_W - RUN_W - 2*VEC_W - IDX_W){1'b0}},
                      m_entry.entry_index, m_entry.vec_y, m_entry.vec_x, m_entry.zero_run};

endmodule
